// ----- rtl/scrq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package scrq_pkg;

  localparam int RING_DEPTH  = 16;
  localparam int EVENT_WIDTH = 16;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int COUNT_W     = 4;
  localparam int MODE_W      = 3;

  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [EVENT_WIDTH-1:0] event_t;
  typedef logic [COUNT_W-1:0]     count_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_STAGE   = 3'd0,
    MODE_COMMIT  = 3'd1,
    MODE_POP     = 3'd2,
    MODE_UNSTAGE = 3'd3,
    MODE_DISCARD = 3'd4,
    MODE_QUERY   = 3'd5
  } mode_t;

  localparam ptr_t PTR_LAST = ptr_t'(RING_DEPTH - 1);

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ring_prev(input ptr_t p);
    ring_prev = (p == '0) ? PTR_LAST : ptr_t'(p - 1'b1);
  endfunction

  // distance from one pointer forward to another, modulo the ring depth
  function automatic ptr_t ring_dist(input ptr_t from_p, input ptr_t to_p);
    logic [PTR_W:0] wide;
    wide = (to_p >= from_p) ? {1'b0, to_p} - {1'b0, from_p}
                            : {1'b0, to_p} + (PTR_W+1)'(RING_DEPTH) - {1'b0, from_p};
    ring_dist = wide[PTR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/scrq_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface scrq_in_if
  import scrq_pkg::*;
  ;
  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  event_t                event_data;

  modport source (output valid, output mode, output event_data, input ready);
  modport sink   (input valid, input mode, input event_data, output ready);
endinterface

interface scrq_out_if
  import scrq_pkg::*;
  ;
  logic   valid;
  logic   ready;
  event_t oldest_event;
  event_t next_staged_event;
  count_t committed_count;
  count_t staged_count;
  logic   error;

  modport source (output valid, output oldest_event, output next_staged_event,
                  output committed_count, output staged_count, output error,
                  input ready);
  modport sink   (input valid, input oldest_event, input next_staged_event,
                  input committed_count, input staged_count, input error,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/staged_commit_ring_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// staged-commit ring queue of events
// in_bus beats carry an operation (mode) and an event word; every accepted beat
// produces exactly one beat on out_bus with the events at tail and head, the
// committed and staged counts and an error flag, all as seen after the operation
// modes: stage, commit, pop, unstage newest, discard staged, query (six and seven
// act as query); an operation that would overflow the ring or underflow a
// region is ignored and flagged
// the result beat is registered first in the read-data and pending registers,
// then in the output register once that register is free
// a new operation is not taken until the last result has reached the output
// register; the slot memory is written and read in the accept cycle
// at most RING_DEPTH-1 events are held, one slot always stays empty
// reset (rst_n low, synchronous) empties all three regions and drops any
// pending result; slot contents are not cleared
// when the receiver stalls the result beat holds in the output register;
// one further operation may be taken and waits until the output is free
module staged_commit_ring_queue
  import scrq_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  scrq_in_if.sink       in_bus,
  scrq_out_if.source    out_bus
);

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  state_t state_r;

  // ring pointers: tail, head, staging head
  ptr_t read_ptr_r,   read_ptr_nxt;
  ptr_t commit_ptr_r, commit_ptr_nxt;
  ptr_t stage_ptr_r,  stage_ptr_nxt;

  // slot memory with registered reads at tail and head
  event_t slot_mem [RING_DEPTH];
  event_t rd_oldest_r;
  event_t rd_staged_r;

  // result fields waiting for the read data
  ptr_t pend_comm_r, pend_stag_r;
  logic pend_err_r;
  ptr_t pend_comm_nxt, pend_stag_nxt;
  logic err_nxt;

  // output register
  logic   out_valid_r;
  event_t out_oldest_r;
  event_t out_staged_r;
  count_t out_comm_r;
  count_t out_stag_r;
  logic   out_err_r;

  logic accept;
  logic wr_en;
  logic out_free;
  ptr_t comm_cnt, stag_cnt, total_cnt;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;

  assign comm_cnt  = ring_dist(read_ptr_r, commit_ptr_r);
  assign stag_cnt  = ring_dist(commit_ptr_r, stage_ptr_r);
  assign total_cnt = ring_dist(read_ptr_r, stage_ptr_r);

  // operation decode, pointer update and error check
  always_comb begin
    read_ptr_nxt   = read_ptr_r;
    commit_ptr_nxt = commit_ptr_r;
    stage_ptr_nxt  = stage_ptr_r;
    err_nxt        = 1'b0;
    wr_en          = 1'b0;
    case (in_bus.mode)
      MODE_STAGE: begin
        if (total_cnt == PTR_LAST) begin
          err_nxt = 1'b1;
        end else begin
          wr_en         = accept;
          stage_ptr_nxt = ring_next(stage_ptr_r);
        end
      end
      MODE_COMMIT: begin
        if (stag_cnt == '0) err_nxt = 1'b1;
        else commit_ptr_nxt = ring_next(commit_ptr_r);
      end
      MODE_POP: begin
        if (comm_cnt == '0) err_nxt = 1'b1;
        else read_ptr_nxt = ring_next(read_ptr_r);
      end
      MODE_UNSTAGE: begin
        if (stag_cnt == '0) err_nxt = 1'b1;
        else stage_ptr_nxt = ring_prev(stage_ptr_r);
      end
      MODE_DISCARD: begin
        stage_ptr_nxt = commit_ptr_r;
      end
      default: begin
      end
    endcase
    pend_comm_nxt = ring_dist(read_ptr_nxt, commit_ptr_nxt);
    pend_stag_nxt = ring_dist(commit_ptr_nxt, stage_ptr_nxt);
  end

  // slot memory: write at the staging head, read at the new tail and head;
  // a head read that hits the slot being written takes the new event
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[stage_ptr_r] <= in_bus.event_data;
    end
    if (accept) begin
      rd_oldest_r <= slot_mem[read_ptr_nxt];
      if (wr_en && (commit_ptr_nxt == stage_ptr_r)) begin
        rd_staged_r <= in_bus.event_data;
      end else begin
        rd_staged_r <= slot_mem[commit_ptr_nxt];
      end
      pend_comm_r <= pend_comm_nxt;
      pend_stag_r <= pend_stag_nxt;
      pend_err_r  <= err_nxt;
    end
  end

  // control, pointers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      read_ptr_r   <= '0;
      commit_ptr_r <= '0;
      stage_ptr_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // in ST_RESP the output register is either reloaded or still stalled
      if (out_valid_r && out_bus.ready && (state_r != ST_RESP)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            read_ptr_r   <= read_ptr_nxt;
            commit_ptr_r <= commit_ptr_nxt;
            stage_ptr_r  <= stage_ptr_nxt;
            state_r      <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            // empty regions report zero
            out_oldest_r <= (pend_comm_r != '0) ? rd_oldest_r : '0;
            out_staged_r <= (pend_stag_r != '0) ? rd_staged_r : '0;
            out_comm_r   <= count_t'(pend_comm_r);
            out_stag_r   <= count_t'(pend_stag_r);
            out_err_r    <= pend_err_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.oldest_event      = out_oldest_r;
  assign out_bus.next_staged_event = out_staged_r;
  assign out_bus.committed_count   = out_comm_r;
  assign out_bus.staged_count      = out_stag_r;
  assign out_bus.error             = out_err_r;

endmodule
`default_nettype wire
